// ===== hw/rtl/wdt_pkg.sv =====
package wdt_pkg;

  localparam int CNT_W  = 32;
  localparam int DATA_W = 32;
  localparam int OFS_W  = 12;
  localparam int WORD_W = OFS_W - 2;

  localparam logic [DATA_W-1:0] UNLOCK_KEY = 32'h1ACC_E551;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [WORD_W-1:0] W_LOAD   = 10'h000;
  localparam logic [WORD_W-1:0] W_VALUE  = 10'h001;
  localparam logic [WORD_W-1:0] W_CTRL   = 10'h002;
  localparam logic [WORD_W-1:0] W_INTCLR = 10'h003;
  localparam logic [WORD_W-1:0] W_RIS    = 10'h004;
  localparam logic [WORD_W-1:0] W_MIS    = 10'h005;
  localparam logic [WORD_W-1:0] W_LOCK   = 10'h300;
  localparam logic [WORD_W-1:0] W_PID0   = 10'h3F8;
  localparam logic [WORD_W-1:0] W_PID1   = 10'h3F9;
  localparam logic [WORD_W-1:0] W_PID2   = 10'h3FA;
  localparam logic [WORD_W-1:0] W_PID3   = 10'h3FB;
  localparam logic [WORD_W-1:0] W_CID0   = 10'h3FC;
  localparam logic [WORD_W-1:0] W_CID1   = 10'h3FD;
  localparam logic [WORD_W-1:0] W_CID2   = 10'h3FE;
  localparam logic [WORD_W-1:0] W_CID3   = 10'h3FF;

  typedef struct packed {
    logic irq;
    logic wd_reset;
  } wdt_status_t;

  function automatic logic [DATA_W-1:0] id_word(input logic [WORD_W-1:0] word);
    logic [DATA_W-1:0] v;
    v = '0;
    unique case (word)
      W_PID0:  v = 32'h05;
      W_PID1:  v = 32'h18;
      W_PID2:  v = 32'h14;
      W_PID3:  v = 32'h00;
      W_CID0:  v = 32'h0D;
      W_CID1:  v = 32'hF0;
      W_CID2:  v = 32'h05;
      W_CID3:  v = 32'hB1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/wdt_core.sv =====
module wdt_core
  import wdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  kind_t             kind,
  input  logic [OFS_W-1:0]  reg_offset,
  input  logic [DATA_W-1:0] write_data,
  output logic [DATA_W-1:0] read_data,
  output wdt_status_t       status
);

  logic [CNT_W-1:0] load_r, load_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic ie_r, ie_nxt;
  logic re_r, re_nxt;
  logic raw_r, raw_nxt;
  logic lock_r, lock_nxt;
  logic flag_r, flag_nxt;
  logic [WORD_W-1:0] word;

  assign word = reg_offset[OFS_W-1:2];

  always_comb begin
    load_nxt = load_r;
    cnt_nxt  = cnt_r;
    ie_nxt   = ie_r;
    re_nxt   = re_r;
    raw_nxt  = raw_r;
    lock_nxt = lock_r;
    flag_nxt = flag_r;
    unique case (kind)
      KIND_TICK: begin
        if (ie_r) begin
          if (cnt_r == '0) begin
            if (raw_r && re_r) begin
              flag_nxt = 1'b1;
            end
            raw_nxt = 1'b1;
            cnt_nxt = load_r;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      KIND_WRITE: begin
        if (word == W_LOCK) begin
          lock_nxt = (write_data != UNLOCK_KEY);
        end else if (!lock_r) begin
          priority if (word == W_LOAD) begin
            load_nxt = write_data[CNT_W-1:0];
            cnt_nxt  = write_data[CNT_W-1:0];
          end else if (word == W_CTRL) begin
            if (write_data[0] && !ie_r) begin
              cnt_nxt = load_r;
            end
            ie_nxt = write_data[0];
            re_nxt = write_data[1];
          end else if (word == W_INTCLR) begin
            raw_nxt = 1'b0;
            cnt_nxt = load_r;
          end else begin
          end
        end
      end
      KIND_READ, KIND_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    read_data = '0;
    if (kind == KIND_READ) begin
      unique case (word)
        W_LOAD:  read_data = DATA_W'(load_r);
        W_VALUE: read_data = DATA_W'(cnt_r);
        W_CTRL:  read_data = DATA_W'({re_r, ie_r});
        W_RIS:   read_data = DATA_W'(raw_r);
        W_MIS:   read_data = DATA_W'(raw_r & ie_r);
        W_LOCK:  read_data = DATA_W'(lock_r);
        default: read_data = id_word(word);
      endcase
    end
  end

  assign status.irq      = raw_nxt & ie_nxt;
  assign status.wd_reset = flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '1;
      cnt_r  <= '1;
      ie_r   <= 1'b0;
      re_r   <= 1'b0;
      raw_r  <= 1'b0;
      lock_r <= 1'b0;
      flag_r <= 1'b0;
    end else if (step) begin
      load_r <= load_nxt;
      cnt_r  <= cnt_nxt;
      ie_r   <= ie_nxt;
      re_r   <= re_nxt;
      raw_r  <= raw_nxt;
      lock_r <= lock_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

// ===== hw/rtl/two_stage_watchdog_timer_unit.sv =====
// Register-mapped two-stage watchdog. Each request is a tick, a register read or a
// register write; it is captured in an input register, processed against the watchdog
// state as it moves on into the output register, and its result (read data, masked
// interrupt and sticky reset request) is held in that output register. One request
// is accepted every clock cycle while results are taken; a stalled output holds one
// result plus one captured request.
module two_stage_watchdog_timer_unit
  import wdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [OFS_W-1:0]  in_reg_offset,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_irq_out,
  output logic              out_reset_out
);

  logic              in_valid_r;
  kind_t             in_kind_r;
  logic [OFS_W-1:0]  in_ofs_r;
  logic [DATA_W-1:0] in_data_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] rd_r;
  logic              irq_r;
  logic              rst_r;
  logic              advance;
  logic              step;
  logic [DATA_W-1:0] rd_nxt;
  wdt_status_t       status_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign step     = advance && in_valid_r;
  assign in_ready = !in_valid_r || advance;

  wdt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .kind       (in_kind_r),
    .reg_offset (in_ofs_r),
    .write_data (in_data_r),
    .read_data  (rd_nxt),
    .status     (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_kind_r <= kind_t'(in_kind);
      in_ofs_r  <= in_reg_offset;
      in_data_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      irq_r       <= 1'b0;
      rst_r       <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        irq_r <= status_nxt.irq;
        rst_r <= status_nxt.wd_reset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rd_r <= rd_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rd_r;
  assign out_irq_out   = irq_r;
  assign out_reset_out = rst_r;

`ifndef ASSERT_OFF
  a_reset_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_reset_out |=> out_reset_out)
    else $error("watchdog reset request dropped");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result produced without a captured request");

  a_capture_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_ofs_r) && $stable(in_data_r))
    else $error("captured request lost while stalled");
`endif

endmodule
